// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL files; only pts_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/pts_pkg.sv -----
`default_nettype none
package pts_pkg;
   localparam int MAX_TOKENS_DEF = 32768;
   localparam int FRAC_BITS      = 16;
   localparam int PROB_W         = FRAC_BITS + 1;
   localparam int COIN_W         = 24;
   localparam int CFG_W          = 64;
   localparam int IDX_W          = 15;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 16;
   localparam int CSR_IDX_W      = 1;

   localparam logic [PROB_W-1:0] ONE         = PROB_W'(1) << FRAC_BITS;
   localparam logic [PROB_W-1:0] TOP_P_RESET = 17'd58982;
   localparam logic [CFG_W-1:0]  SEED_RESET  = 64'd1;
   localparam logic [63:0]       XS_MULT     = 64'h2545F4914F6CDD1D;
   localparam int SH_A = 12;
   localparam int SH_B = 25;
   localparam int SH_C = 27;

   localparam logic [CSR_IDX_W-1:0] REG_TOP_P    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_RNG_SEED = 1'b1;

   typedef struct packed {
      logic                 we;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     wdata;
   } csr_wr_type;
endpackage
`default_nettype wire

// ----- hdl/pts_store.sv -----
`default_nettype none
module pts_store #(
   parameter int MAX_TOKENS = pts_pkg::MAX_TOKENS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(MAX_TOKENS)-1:0]     wr_addr,
   input  wire logic [pts_pkg::PROB_W-1:0]        wr_data,
   input  wire logic                              rd_en,
   input  wire logic [$clog2(MAX_TOKENS)-1:0]     rd_addr,
   output logic      [pts_pkg::PROB_W-1:0]        rd_data
);
   import pts_pkg::*;

   logic [PROB_W-1:0] mem [MAX_TOKENS];
   logic [PROB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- hdl/pts_job_fifo.sv -----
`default_nettype none
module pts_job_fifo #(
   parameter int WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] dout,
   output logic                  valid
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign dout    = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= din;
      end
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wptr_ff <= !wptr_ff;
         if (do_pop)  rptr_ff <= !rptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule
`default_nettype wire

// ----- hdl/pts_front.sv -----
`default_nettype none
module pts_front #(
   parameter int MAX_TOKENS = pts_pkg::MAX_TOKENS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [pts_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                req_tlast,
   output logic                                     wr_en,
   output logic      [$clog2(MAX_TOKENS)-1:0]       wr_addr,
   output logic      [pts_pkg::PROB_W-1:0]          wr_data,
   output logic                                     job_push,
   output logic      [$clog2(MAX_TOKENS+1)-1:0]     job_n,
   input  wire logic                                job_full,
   input  wire logic                                done
);
   import pts_pkg::*;

   localparam int AW = $clog2(MAX_TOKENS);
   localparam int CW = $clog2(MAX_TOKENS + 1);
   localparam logic [CW-1:0] MAX_N = CW'(MAX_TOKENS);

   logic [CW-1:0] count_ff;
   logic          wait_ff;
   logic          accept, room;

   // The store is owned by the back end while a vector is sampled.
   assign req_tready = !wait_ff && !job_full;
   assign accept     = req_tvalid && req_tready;
   assign room       = (count_ff < MAX_N);

   assign wr_en    = accept && room;
   assign wr_addr  = count_ff[AW-1:0];
   assign wr_data  = req_tdata[PROB_W-1:0];
   assign job_push = accept && req_tlast;
   assign job_n    = count_ff + {{(CW-1){1'b0}}, room};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wait_ff  <= 1'b0;
      end else begin
         if (job_push) begin
            count_ff <= '0;
            wait_ff  <= 1'b1;
         end else if (wr_en) begin
            count_ff <= count_ff + 1'b1;
         end
         if (done) wait_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// ----- hdl/pts_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module pts_back #(
   parameter int MAX_TOKENS = pts_pkg::MAX_TOKENS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pts_pkg::csr_wr_type                 csr,
   input  wire logic                                job_valid,
   input  wire logic [$clog2(MAX_TOKENS+1)-1:0]     job_n,
   output logic                                     job_pop,
   output logic                                     rd_en,
   output logic      [$clog2(MAX_TOKENS)-1:0]       rd_addr,
   input  wire logic [pts_pkg::PROB_W-1:0]          rd_data,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [pts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                     done
);
   import pts_pkg::*;

   localparam int AW    = $clog2(MAX_TOKENS);
   localparam int CW    = $clog2(MAX_TOKENS + 1);
   localparam int SUM_W = PROB_W + CW;
   localparam int TW    = SUM_W + COIN_W;
   localparam int CSH   = COIN_W - FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RNG, ST_MUL0, ST_MUL1, ST_MUL2, ST_COIN,
      ST_SCAN, ST_PASS_END, ST_TARGET, ST_RESULT
   } state_type;

   state_type           state_ff;
   logic [PROB_W-1:0]   top_p_ff;
   logic [63:0]         rng_ff;
   logic [31:0]         p0_ff, p1_ff, p2_ff;
   logic [COIN_W-1:0]   coin_ff;
   logic [CW-1:0]       n_ff, nm1_ff, issue_ff;
   logic                single_ff, plain_ff, phase2_ff;
   logic [PROB_W-1:0]   thresh_ff;
   logic                rd_vld_ff;
   logic [AW-1:0]       rd_idx_ff;
   logic                have_prev_ff, best_vld_ff, found_ff;
   logic [PROB_W-1:0]   prev_p_ff, best_p_ff;
   logic [AW-1:0]       prev_i_ff, best_i_ff, lastk_ff, res_ff;
   logic [SUM_W-1:0]    cdf_ff, cum_ff;
   logic [TW-1:0]       target_ff;
   logic                rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [31:0]         mul_a, mul_b;
   logic [63:0]         mul_p;
   logic [31:0]         coin_sum;
   logic [63:0]         rng_in;
   logic [PROB_W+CW-1:0] keep_prod;
   logic                kept, cand, better, issuing, out_free;
   logic [SUM_W-1:0]    cdf_step_in, cdf_next_in, cum_next_in;
   logic                hit_plain, hit_nuc, over;
   logic [TW-1:0]       target_in;

   // Shared 32 by 32 multiplier for the output mix of the generator.
   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin
            mul_a = rng_ff[63:32];
            mul_b = XS_MULT[31:0];
         end
         ST_MUL2: begin
            mul_a = rng_ff[31:0];
            mul_b = XS_MULT[63:32];
         end
         default: begin
            mul_a = rng_ff[31:0];
            mul_b = XS_MULT[31:0];
         end
      endcase
   end
   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   // Upper word of the 64-bit product; the coin is its top 24 bits.
   assign coin_sum = p0_ff + p1_ff + p2_ff;

   always_comb begin
      rng_in = rng_ff ^ (rng_ff >> SH_A);
      rng_in = rng_in ^ (rng_in << SH_B);
      rng_in = rng_in ^ (rng_in >> SH_C);
   end

   assign keep_prod = rd_data * nm1_ff;
   assign kept      = single_ff || (keep_prod >= (PROB_W+CW)'(thresh_ff));
   assign cand      = kept && (!have_prev_ff || (rd_data < prev_p_ff) ||
                      ((rd_data == prev_p_ff) && (rd_idx_ff > prev_i_ff)));
   assign better    = !best_vld_ff || (rd_data > best_p_ff);

   assign cdf_step_in = cdf_ff + SUM_W'(rd_data);
   assign hit_plain   = TW'(coin_ff) < TW'({cdf_step_in, {CSH{1'b0}}});
   assign cdf_next_in = cdf_ff + SUM_W'(best_p_ff);
   assign hit_nuc     = target_ff < {cdf_next_in, {COIN_W{1'b0}}};
   assign cum_next_in = cum_ff + SUM_W'(best_p_ff);
   assign over        = cum_next_in > SUM_W'(top_p_ff);
   assign target_in   = TW'(coin_ff) * TW'(cum_ff);

   assign issuing  = (state_ff == ST_SCAN) && (issue_ff < n_ff);
   assign rd_en    = issuing;
   assign rd_addr  = issue_ff[AW-1:0];
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign job_pop  = (state_ff == ST_IDLE) && job_valid;
   assign done     = (state_ff == ST_RESULT) && out_free;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         top_p_ff   <= TOP_P_RESET;
         rng_ff     <= SEED_RESET;
         rsp_vld_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (csr.we && (csr.index == REG_TOP_P))    top_p_ff <= csr.wdata[PROB_W-1:0];
         if (csr.we && (csr.index == REG_RNG_SEED)) rng_ff   <= csr.wdata;
         if (rsp_tready && !done) rsp_vld_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  n_ff      <= job_n;
                  nm1_ff    <= job_n - 1'b1;
                  single_ff <= (job_n == CW'(1));
                  state_ff  <= ST_RNG;
               end
            end
            ST_RNG: begin
               rng_ff   <= rng_in;
               state_ff <= ST_MUL0;
            end
            ST_MUL0: begin
               p0_ff    <= mul_p[63:32];
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               p1_ff    <= mul_p[31:0];
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               p2_ff    <= mul_p[31:0];
               state_ff <= ST_COIN;
            end
            ST_COIN: begin
               coin_ff      <= coin_sum[31:32-COIN_W];
               plain_ff     <= (top_p_ff == '0) || (top_p_ff >= ONE);
               thresh_ff    <= ONE - top_p_ff;
               phase2_ff    <= 1'b0;
               have_prev_ff <= 1'b0;
               best_vld_ff  <= 1'b0;
               found_ff     <= 1'b0;
               cdf_ff       <= '0;
               cum_ff       <= '0;
               issue_ff     <= '0;
               rd_vld_ff    <= 1'b0;
               state_ff     <= ST_SCAN;
            end
            ST_SCAN: begin
               if (issuing) issue_ff <= issue_ff + 1'b1;
               rd_vld_ff <= issuing;
               rd_idx_ff <= issue_ff[AW-1:0];
               if (rd_vld_ff) begin
                  if (plain_ff) begin
                     cdf_ff <= cdf_step_in;
                     if (!found_ff && hit_plain) begin
                        found_ff <= 1'b1;
                        res_ff   <= rd_idx_ff;
                     end
                  end else if (cand && better) begin
                     best_vld_ff <= 1'b1;
                     best_p_ff   <= rd_data;
                     best_i_ff   <= rd_idx_ff;
                  end
               end
               if (!issuing && !rd_vld_ff) state_ff <= ST_PASS_END;
            end
            ST_PASS_END: begin
               issue_ff    <= '0;
               best_vld_ff <= 1'b0;
               if (plain_ff) begin
                  if (!found_ff) res_ff <= AW'(n_ff - 1'b1);
                  state_ff <= ST_RESULT;
               end else if (!phase2_ff) begin
                  if (!best_vld_ff) begin
                     if (!have_prev_ff) begin
                        // Nothing passed the cutoff.
                        res_ff   <= AW'(n_ff - 1'b1);
                        state_ff <= ST_RESULT;
                     end else begin
                        lastk_ff <= prev_i_ff;
                        state_ff <= ST_TARGET;
                     end
                  end else begin
                     cum_ff       <= cum_next_in;
                     prev_p_ff    <= best_p_ff;
                     prev_i_ff    <= best_i_ff;
                     have_prev_ff <= 1'b1;
                     if (over) begin
                        lastk_ff <= best_i_ff;
                        state_ff <= ST_TARGET;
                     end else begin
                        state_ff <= ST_SCAN;
                     end
                  end
               end else begin
                  cdf_ff       <= cdf_next_in;
                  prev_p_ff    <= best_p_ff;
                  prev_i_ff    <= best_i_ff;
                  have_prev_ff <= 1'b1;
                  if (hit_nuc || (best_i_ff == lastk_ff)) begin
                     res_ff   <= best_i_ff;
                     state_ff <= ST_RESULT;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_TARGET: begin
               target_ff    <= target_in;
               phase2_ff    <= 1'b1;
               have_prev_ff <= 1'b0;
               best_vld_ff  <= 1'b0;
               cdf_ff       <= '0;
               issue_ff     <= '0;
               state_ff     <= ST_SCAN;
            end
            ST_RESULT: begin
               if (out_free) begin
                  rsp_vld_ff  <= 1'b1;
                  rsp_data_ff <= RSP_DATA_W'(IDX_W'(res_ff));
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_rsp_from_result, clock, reset, $rose(rsp_vld_ff) |-> $past(state_ff == ST_RESULT), "result register loaded outside the result state")
   `ASSERT_CLK(a_pop_idle, clock, reset, job_pop |-> (state_ff == ST_IDLE), "job taken while busy")
   `ASSERT_CLK(a_phase2_best, clock, reset, ((state_ff == ST_PASS_END) && !plain_ff && phase2_ff) |-> best_vld_ff, "sampling pass ran out of entries before the truncation point")
endmodule
`default_nettype wire

// ----- hdl/top_p_token_sampler.sv -----
// Plain sampling draws the coin after the last transaction, then scans the store once.
// Nucleus sampling runs one scan of the store per selected entry, twice over the kept head:
// once to find the truncation point and again to draw the sample from it.
// Loads take one transaction per cycle while ready; the store read port sets the scan rate.
// A new vector is accepted once the previous token has entered the output register.
// Reset is synchronous and active high: top_p returns to 58982 and the generator state to 1.
`default_nettype none
module top_p_token_sampler #(
   parameter int MAX_TOKENS = pts_pkg::MAX_TOKENS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request transactions: one probability each.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [pts_pkg::REQ_DATA_W-1:0]  req_tdata,   // [16:0] prob, rest zero
   input  wire logic                            req_tlast,   // last probability of the vector
   // Response transactions: one token index per vector.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [pts_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [14:0] token_index, rest zero
   // Configuration writes.
   input  wire logic                            csr_we,
   input  wire logic [pts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pts_pkg::CFG_W-1:0]       csr_wdata
);
   import pts_pkg::*;

   localparam int AW = $clog2(MAX_TOKENS);
   localparam int CW = $clog2(MAX_TOKENS + 1);

   // The front end stores probabilities and hands each finished vector to
   // the back end through a small job queue, then waits until the back end
   // is done reading the store.
   logic              wr_en, rd_en, job_push, job_full, job_pop, job_valid, done;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [PROB_W-1:0] wr_data, rd_data;
   logic [CW-1:0]     push_n, pop_n;
   csr_wr_type        csr;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   pts_front #(.MAX_TOKENS(MAX_TOKENS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .wr_en, .wr_addr, .wr_data, .job_push, .job_n(push_n), .job_full, .done
   );

   pts_store #(.MAX_TOKENS(MAX_TOKENS)) u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data
   );

   pts_job_fifo #(.WIDTH(CW)) u_queue (
      .clock, .reset, .push(job_push), .din(push_n), .full(job_full),
      .pop(job_pop), .dout(pop_n), .valid(job_valid)
   );

   // The back end draws the coin and runs the selection scans.
   pts_back #(.MAX_TOKENS(MAX_TOKENS)) u_back (
      .clock, .reset, .csr, .job_valid, .job_n(pop_n), .job_pop,
      .rd_en, .rd_addr, .rd_data, .rsp_tvalid, .rsp_tready, .rsp_tdata, .done
   );
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
   import pts_pkg::*;

   // Kinds of rows in the directed table: a register write or one probability transaction.
   typedef enum logic [0:0] {ROW_CSR, ROW_PROB} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [CSR_IDX_W-1:0] reg_index;  // register for ROW_CSR
      logic [63:0]      value;          // register value or probability
      bit               last;
      bit               typed;          // expected token typed in below
      logic [IDX_W-1:0] token;
   } row_type;

   localparam int WATCHDOG_LIMIT = 100000;
   localparam int SETTLE_CYCLES  = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   top_p_token_sampler DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Shadow copy of the sampler: its registers, generator and probability store.
   logic [PROB_W-1:0] shadow_top_p;
   logic [63:0]       shadow_rng;
   logic [PROB_W-1:0] prob_store [MAX_TOKENS_DEF];
   int unsigned       prob_count;
   int unsigned       kept_idx [MAX_TOKENS_DEF];

   // Token indexes still owed by the sampler, oldest first, and the typed-in
   // values that override the prediction for directed vectors.
   logic [IDX_W-1:0]  token_q [$];
   bit                typed_valid_q [$];
   logic [IDX_W-1:0]  typed_token_q [$];

   int unsigned errors = 0;
   int unsigned probs_sent = 0;
   int unsigned vectors_sent = 0;
   int unsigned tokens_checked = 0;
   int unsigned idle_cycles = 0;
   bit          hold_go = 0;
   int unsigned burst_left = 0;

   // Advances the xorshift64* generator and returns the 24-bit coin.
   function automatic logic [63:0] next_coin();
      logic [63:0] s;
      logic [63:0] prod;
      s = shadow_rng;
      s = s ^ (s >> SH_A);
      s = s ^ (s << SH_B);
      s = s ^ (s >> SH_C);
      shadow_rng = s;
      prod = s * XS_MULT;
      return prod >> 40;
   endfunction

   // Inverse CDF over every stored entry.
   function automatic int unsigned pick_multinomial(int unsigned n, logic [63:0] coin);
      logic [63:0] cdf;
      cdf = 0;
      for (int unsigned i = 0; i < n; i++) begin
         cdf += prob_store[i];
         if ((coin << FRAC_BITS) < (cdf << COIN_W)) return i;
      end
      return n - 1;
   endfunction

   // Cutoff, sort by descending probability (lower index wins ties), truncate and sample.
   function automatic int unsigned pick_nucleus(int unsigned n, logic [63:0] tp,
                                                logic [63:0] coin);
      logic [63:0] thresh, cum, cdf, target, p;
      int unsigned kept, lastk, j, tmp;
      thresh = (64'd1 << FRAC_BITS) - tp;
      kept = 0;
      for (int unsigned i = 0; i < n; i++) begin
         p = prob_store[i];
         if (n == 1 || p * (n - 1) >= thresh) begin
            // Insertion keeps earlier indexes ahead of equal probabilities.
            j = kept;
            while (j > 0 && prob_store[kept_idx[j-1]] < prob_store[i]) begin
               kept_idx[j] = kept_idx[j-1];
               j--;
            end
            kept_idx[j] = i;
            kept++;
         end
      end
      if (kept == 0) return n - 1;
      lastk = kept - 1;
      cum = 0;
      for (int unsigned i = 0; i < kept; i++) begin
         cum += prob_store[kept_idx[i]];
         if (cum > tp) begin
            lastk = i;
            break;
         end
      end
      target = coin * cum;
      cdf = 0;
      for (int unsigned i = 0; i <= lastk; i++) begin
         cdf += prob_store[kept_idx[i]];
         if (target < (cdf << COIN_W)) return kept_idx[i];
      end
      tmp = kept_idx[lastk];
      return tmp;
   endfunction

   // One accepted probability; returns 1 with the sampled token when it closes a vector.
   function automatic bit sample_token(logic [PROB_W-1:0] prob, bit last,
                                       output logic [IDX_W-1:0] token);
      int unsigned n, idx;
      logic [63:0] coin;
      token = '0;
      if (prob_count < MAX_TOKENS_DEF) begin
         prob_store[prob_count] = prob;
         prob_count++;
      end
      if (!last) return 0;
      n = prob_count;
      prob_count = 0;
      coin = next_coin();
      if (shadow_top_p == 0 || shadow_top_p >= ONE) idx = pick_multinomial(n, coin);
      else idx = pick_nucleus(n, shadow_top_p, coin);
      token = idx[IDX_W-1:0];
      return 1;
   endfunction

   // Request monitor: every accepted probability goes through the shadow model.
   always @(posedge clock) begin
      logic [IDX_W-1:0] tok;
      if (!reset && req_tvalid && req_tready) begin
         if (sample_token(req_tdata[PROB_W-1:0], req_tlast, tok)) begin
            if (typed_valid_q.size() > 0 && typed_valid_q[0]) tok = typed_token_q[0];
            if (typed_valid_q.size() > 0) begin
               void'(typed_valid_q.pop_front());
               void'(typed_token_q.pop_front());
            end
            token_q.push_back(tok);
         end
      end
   end

   // Response checker: each token is compared with the oldest one owed.
   always @(posedge clock) begin
      logic [IDX_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (token_q.size() == 0) begin
            $display("%0t: unexpected token transaction, actual %0d", $time, rsp_tdata);
            errors++;
         end else begin
            want = token_q.pop_front();
            tokens_checked++;
            if (rsp_tdata !== {{(RSP_DATA_W-IDX_W){1'b0}}, want}) begin
               $display("%0t: token_index mismatch, expected %0d, actual %0d",
                        $time, want, rsp_tdata);
               errors++;
            end
         end
      end
   end

   // Receiver: switches at random between stall patterns, and on request holds off for a long
   // stretch so the sampler backs up and stops accepting probabilities.
   initial begin
      int unsigned hold_cnt, mode, mode_left;
      hold_cnt = 0;
      mode = 0;
      mode_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 0;
            hold_cnt = 600;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog on cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offers one probability; the sender works in bursts with random gaps between them.
   task automatic send_prob(logic [PROB_W-1:0] prob, bit last, bit typed,
                            logic [IDX_W-1:0] token);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (last) begin
         typed_valid_q.push_back(typed);
         typed_token_q.push_back(token);
         vectors_sent++;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-PROB_W){1'b0}}, prob};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      probs_sent++;
   endtask

   // Waits until every owed token has come back, then lets the sampler settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (token_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, issued only with the sampler idle.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [63:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_TOP_P) shadow_top_p = value[PROB_W-1:0];
      else shadow_rng = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One random vector with one of several probability shapes.
   task automatic send_random_vector();
      int unsigned n, shape, left, p;
      shape = $urandom_range(0, 3);
      case ($urandom_range(0, 19))
         0: n = $urandom_range(25, 48);
         1, 2, 3, 4, 5: n = $urandom_range(11, 24);
         default: n = $urandom_range(1, 10);
      endcase
      left = ONE;
      for (int unsigned i = 0; i < n; i++) begin
         case (shape)
            0: begin
               // Pieces of one whole, roughly a proper distribution.
               p = (i == n - 1) ? left : $urandom_range(0, left);
               left -= p;
            end
            1: p = $urandom_range(0, ONE);
            2: p = $urandom_range(0, (1 << PROB_W) - 1);
            default: p = (i == 0 || $urandom_range(0, 4) == 0) ?
                         $urandom_range(20000, ONE) : $urandom_range(0, 600);
         endcase
         send_prob(p[PROB_W-1:0], i == n - 1, 0, '0);
      end
   endtask

   task automatic random_config();
      case ($urandom_range(0, 5))
         0: write_csr(REG_TOP_P, 0);
         1: write_csr(REG_TOP_P, ONE);
         2: write_csr(REG_TOP_P, $urandom_range(1, 4));
         3: write_csr(REG_TOP_P, $urandom_range(ONE - 4, ONE - 1));
         4: write_csr(REG_TOP_P, $urandom_range(1, ONE - 1));
         default: write_csr(REG_RNG_SEED, {$urandom, $urandom});
      endcase
   endtask

   // Directed vectors. Rows with a typed token are simple enough to read off directly.
   row_type directed [] = '{
      // Reset settings: top_p near 0.9, generator at 1.
      '{ROW_PROB, REG_TOP_P, 20000, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 45536, 1, 0, 0},
      // A zero seed freezes the coin at zero: plain sampling lands on the first nonzero entry.
      '{ROW_CSR, REG_TOP_P, 0, 0, 0, 0},
      '{ROW_CSR, REG_RNG_SEED, 0, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 0, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 0, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 5, 1, 1, 2},
      // All probabilities zero: the fallback is the last entry.
      '{ROW_PROB, REG_TOP_P, 0, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 0, 1, 1, 1},
      // Smallest top_p: nothing survives the cutoff, so the last entry is taken.
      '{ROW_CSR, REG_RNG_SEED, 1, 0, 0, 0},
      '{ROW_CSR, REG_TOP_P, 1, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 1, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 1, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 1, 1, 1, 2},
      // A single entry is always kept, even above one.
      '{ROW_PROB, REG_TOP_P, 131071, 1, 1, 0},
      // top_p of exactly one, then beyond one: plain sampling.
      '{ROW_CSR, REG_TOP_P, 65536, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 65536, 1, 1, 0},
      '{ROW_CSR, REG_TOP_P, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 100, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 65436, 1, 0, 0},
      // Widest seed and the largest top_p that still selects nucleus sampling.
      '{ROW_CSR, REG_RNG_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0},
      '{ROW_CSR, REG_TOP_P, 65535, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 65535, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 1, 1, 0, 0},
      '{ROW_CSR, REG_TOP_P, 32768, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 30000, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 30000, 0, 0, 0},
      '{ROW_PROB, REG_TOP_P, 5536, 1, 0, 0}
   };

   initial begin
      int unsigned target;
      bit          hold_done, pause_done;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      shadow_top_p = TOP_P_RESET;
      shadow_rng   = SEED_RESET;
      prob_count   = 0;
      hold_done    = 0;
      pause_done   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) write_csr(directed[i].reg_index, directed[i].value);
         else send_prob(directed[i].value[PROB_W-1:0], directed[i].last,
                        directed[i].typed, directed[i].token);
      end

      write_csr(REG_TOP_P, TOP_P_RESET);

      target = probs_sent + 730;
      while (probs_sent < target) begin
         if ($urandom_range(0, 5) == 0) random_config();
         if (!hold_done && probs_sent > target - 500) begin
            // Long receiver hold-off while the sender keeps offering vectors.
            hold_done = 1;
            hold_go = 1;
            repeat (8) send_random_vector();
         end else if (!pause_done && probs_sent > target - 250) begin
            // Sender pause until every owed token has arrived.
            pause_done = 1;
            drain();
         end
         send_random_vector();
      end

      drain();
      $display("Covered %0d probabilities in %0d vectors, %0d tokens checked,",
               probs_sent, vectors_sent, tokens_checked);
      $display("with plain and nucleus sampling, register extremes and long output stalls.");
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire
